/* design/binary_heap_priority_queue_top_defines.svh */
// Assertion macros used by the checker module.
`ifndef BINARY_HEAP_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define BINARY_HEAP_PRIORITY_QUEUE_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BHPQ_ASSERT_SAME(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BHPQ_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/bhpq_pkg.sv */
package bhpq_pkg;

   localparam int CAPACITY_DEFAULT = 1024;
   localparam int VALUE_W          = 32;
   localparam int COUNT_FIELD_W    = 11;

   localparam logic REQ_PUSH = 1'b0;
   localparam logic REQ_POP  = 1'b1;

   typedef struct packed {
      logic                      req_type;
      logic signed [VALUE_W-1:0] push_value;
   } bhpq_req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] root_value;
      logic                      is_empty;
      logic [COUNT_FIELD_W-1:0]  entry_count;
      logic                      req_error;
   } bhpq_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UP,
      ST_DN_LAST,
      ST_DN,
      ST_FINAL,
      ST_RESP
   } bhpq_state_type;

   // True when a must sit above b under the selected ordering.
   function automatic logic ranks_above(input logic max_mode,
                                        input logic signed [VALUE_W-1:0] a,
                                        input logic signed [VALUE_W-1:0] b);
      if (max_mode) begin
         return a > b;
      end
      return a < b;
   endfunction

endpackage

/* design/binary_heap_priority_queue_top.sv */
// Channel   Ports                          Transfer
// request   start, busy, req_data          start high while busy is low
// result    rsp_valid, rsp_data            rsp_valid high for one cycle
// csr       csr_valid, csr_ready, csr_wdata csr_valid and csr_ready high
//
// A push or a pop moves one heap level per cycle, over the memory's two read ports.
// The result appears in the same cycle that busy falls, and a new request is taken then.
// Reset empties the heap and selects max ordering; the memory itself is not cleared.
// The result receiver cannot stall the block.
module binary_heap_priority_queue_top #(
   parameter int CAPACITY = bhpq_pkg::CAPACITY_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  bhpq_pkg::bhpq_req_type req_data,
   output logic                   rsp_valid,
   output bhpq_pkg::bhpq_rsp_type rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic                   csr_wdata
);
   import bhpq_pkg::*;

   localparam int ADDR_W = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int IDX_W  = ADDR_W + 2;

   logic signed [VALUE_W-1:0] heap_mem [CAPACITY];

   bhpq_state_type            state_ff, state_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [ADDR_W-1:0]         hole_ff, hole_in;
   logic signed [VALUE_W-1:0] carry_ff, carry_in;
   logic                      err_ff, err_in;
   logic                      mode_ff;
   logic signed [VALUE_W-1:0] root_ff;
   logic signed [VALUE_W-1:0] rd_a_ff, rd_b_ff;
   logic [ADDR_W-1:0]         left_idx_ff, left_idx_in;
   logic [ADDR_W-1:0]         right_idx_ff, right_idx_in;
   logic                      right_ok_ff, right_ok_in;
   logic                      rsp_valid_ff;
   bhpq_rsp_type              rsp_ff;

   logic                      wr_en;
   logic [ADDR_W-1:0]         wr_addr;
   logic signed [VALUE_W-1:0] wr_data;
   logic                      rd_en;
   logic [ADDR_W-1:0]         rd_addr_a, rd_addr_b;

   logic                      accept;
   logic                      is_full;
   logic [ADDR_W-1:0]         push_parent;
   logic [ADDR_W-1:0]         last_idx;
   logic [ADDR_W-1:0]         parent_idx;
   logic                      up_move;
   logic                      pick_right;
   logic signed [VALUE_W-1:0] pick_val;
   logic [ADDR_W-1:0]         pick_idx;
   logic                      dn_move;
   logic [ADDR_W-1:0]         dn_hole;
   logic [IDX_W-1:0]          left_w, right_w;
   logic                      left_ok, right_ok;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign is_full     = (count_ff == CNT_W'(CAPACITY));
   assign push_parent = ADDR_W'((count_ff - 1'b1) >> 1);
   assign last_idx    = ADDR_W'(count_ff - 1'b1);
   assign parent_idx  = ADDR_W'((hole_ff - 1'b1) >> 1);
   assign up_move     = ranks_above(mode_ff, carry_ff, rd_a_ff);
   assign pick_right  = right_ok_ff && ranks_above(mode_ff, rd_b_ff, rd_a_ff);
   assign pick_val    = pick_right ? rd_b_ff : rd_a_ff;
   assign pick_idx    = pick_right ? right_idx_ff : left_idx_ff;
   assign dn_move     = ranks_above(mode_ff, pick_val, carry_ff);
   assign dn_hole     = (state_ff == ST_DN) ? pick_idx : '0;
   assign left_w      = {1'b0, dn_hole, 1'b1};
   assign right_w     = left_w + 1'b1;
   assign left_ok     = left_w < IDX_W'(count_ff);
   assign right_ok    = right_w < IDX_W'(count_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.req_type == REQ_PUSH) begin
                  if (is_full) begin
                     state_in = ST_RESP;
                  end else if (count_ff == '0) begin
                     state_in = ST_FINAL;
                  end else begin
                     state_in = ST_UP;
                  end
               end else begin
                  if (count_ff <= CNT_W'(1)) begin
                     state_in = ST_RESP;
                  end else begin
                     state_in = ST_DN_LAST;
                  end
               end
            end
         end
         ST_UP: begin
            if (up_move && (parent_idx != '0)) begin
               state_in = ST_UP;
            end else begin
               state_in = ST_FINAL;
            end
         end
         ST_DN_LAST: begin
            state_in = left_ok ? ST_DN : ST_FINAL;
         end
         ST_DN: begin
            state_in = (dn_move && left_ok) ? ST_DN : ST_FINAL;
         end
         ST_FINAL: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      count_in     = count_ff;
      hole_in      = hole_ff;
      carry_in     = carry_ff;
      err_in       = err_ff;
      left_idx_in  = left_idx_ff;
      right_idx_in = right_idx_ff;
      right_ok_in  = right_ok_ff;
      wr_en        = 1'b0;
      wr_addr      = hole_ff;
      wr_data      = carry_ff;
      rd_en        = 1'b0;
      rd_addr_a    = parent_idx;
      rd_addr_b    = parent_idx;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               err_in = 1'b0;
               if (req_data.req_type == REQ_PUSH) begin
                  if (is_full) begin
                     err_in = 1'b1;
                  end else begin
                     count_in  = count_ff + 1'b1;
                     hole_in   = ADDR_W'(count_ff);
                     carry_in  = req_data.push_value;
                     rd_en     = 1'b1;
                     rd_addr_a = push_parent;
                  end
               end else begin
                  if (count_ff == '0) begin
                     err_in = 1'b1;
                  end else begin
                     count_in  = count_ff - 1'b1;
                     hole_in   = '0;
                     rd_en     = 1'b1;
                     rd_addr_a = last_idx;
                  end
               end
            end
         end
         ST_UP: begin
            if (up_move) begin
               wr_en     = 1'b1;
               wr_addr   = hole_ff;
               wr_data   = rd_a_ff;
               hole_in   = parent_idx;
               rd_en     = 1'b1;
               rd_addr_a = ADDR_W'((parent_idx - 1'b1) >> 1);
            end
         end
         ST_DN_LAST, ST_DN: begin
            if (state_ff == ST_DN_LAST) begin
               carry_in = rd_a_ff;
            end else if (dn_move) begin
               wr_en   = 1'b1;
               wr_addr = hole_ff;
               wr_data = pick_val;
               hole_in = pick_idx;
            end
            left_idx_in  = left_w[ADDR_W-1:0];
            right_idx_in = right_ok ? right_w[ADDR_W-1:0] : left_w[ADDR_W-1:0];
            right_ok_in  = right_ok;
            rd_en        = left_ok;
            rd_addr_a    = left_w[ADDR_W-1:0];
            rd_addr_b    = right_ok ? right_w[ADDR_W-1:0] : left_w[ADDR_W-1:0];
         end
         ST_FINAL: begin
            wr_en   = 1'b1;
            wr_addr = hole_ff;
            wr_data = carry_ff;
         end
         ST_RESP: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         heap_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= heap_mem[rd_addr_a];
         rd_b_ff <= heap_mem[rd_addr_b];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         mode_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= (state_ff == ST_RESP);
         if (csr_valid && csr_ready) begin
            mode_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      hole_ff      <= hole_in;
      carry_ff     <= carry_in;
      err_ff       <= err_in;
      left_idx_ff  <= left_idx_in;
      right_idx_ff <= right_idx_in;
      right_ok_ff  <= right_ok_in;
      if (wr_en && (wr_addr == '0)) begin
         root_ff <= wr_data;
      end
      if (state_ff == ST_RESP) begin
         rsp_ff.root_value  <= (count_ff != '0) ? root_ff : '0;
         rsp_ff.is_empty    <= (count_ff == '0);
         rsp_ff.entry_count <= COUNT_FIELD_W'(count_ff);
         rsp_ff.req_error   <= err_ff;
      end
   end

endmodule

/* design/bhpq_checker.sv */
`include "binary_heap_priority_queue_top_defines.svh"

module bhpq_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input logic                   rsp_valid,
   input bhpq_pkg::bhpq_rsp_type rsp_data
);
   import bhpq_pkg::*;

   `BHPQ_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")
   `BHPQ_ASSERT_SAME(a_rsp_idle, rsp_valid, !busy, "result shown while a request is in work")
   `BHPQ_ASSERT_NEXT(a_rsp_single, rsp_valid, !rsp_valid, "result strobe lasted two cycles")
   `BHPQ_ASSERT_SAME(a_empty_fields, rsp_valid && rsp_data.is_empty,
      (rsp_data.entry_count == '0) && (rsp_data.root_value == '0),
      "empty result with nonzero count or root")

endmodule

bind binary_heap_priority_queue_top bhpq_checker u_checker (.*);

/* dv/tb_binary_heap_priority_queue_top.sv */
module tb_binary_heap_priority_queue_top;
   import bhpq_pkg::*;

   localparam int HEAP_DEPTH  = CAPACITY_DEFAULT;
   localparam int FILL_ITEMS  = 150;
   localparam int STALL_LIMIT = 3000;
   localparam int TAIL_CYCLES = 40;

   typedef enum logic [1:0] {
      JOB_REQ,
      JOB_CSR,
      JOB_DRAIN
   } job_kind_type;

   typedef struct {
      job_kind_type kind;
      bhpq_req_type req;
      logic         csr_value;
      int           gap;
   } job_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   bhpq_req_type req_data = '0;
   logic         rsp_valid;
   bhpq_rsp_type rsp_data;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic         csr_wdata = 1'b0;

   job_type      pending_jobs[$];
   bhpq_rsp_type expected_status[$];

   logic signed [VALUE_W-1:0] heap_mem[HEAP_DEPTH];
   int   heap_fill = 0;
   logic heap_max  = 1'b1;

   int   items_issued   = 0;
   int   results_seen   = 0;
   int   mismatch_count = 0;
   int   wait_cycles    = 0;
   bit   gap_loaded     = 1'b0;
   int   stall_cycles   = 0;
   bit   phase_idle     = 1'b1;

   binary_heap_priority_queue_top #(
      .CAPACITY(HEAP_DEPTH)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   function automatic bit outranks(input logic signed [VALUE_W-1:0] a,
                                   input logic signed [VALUE_W-1:0] b);
      if (heap_max) begin
         return a > b;
      end
      return a < b;
   endfunction

   function automatic void swap_slots(input int i, input int j);
      logic signed [VALUE_W-1:0] tmp;
      tmp         = heap_mem[i];
      heap_mem[i] = heap_mem[j];
      heap_mem[j] = tmp;
   endfunction

   function automatic bhpq_rsp_type heap_apply(input bhpq_req_type r);
      int           pos;
      int           parent;
      int           left;
      int           best;
      logic         err;
      bhpq_rsp_type res;
      err = 1'b0;
      if (r.req_type == REQ_PUSH) begin
         if (heap_fill >= HEAP_DEPTH) begin
            err = 1'b1;
         end else begin
            heap_mem[heap_fill] = r.push_value;
            pos = heap_fill;
            heap_fill++;
            while (pos > 0) begin
               parent = (pos - 1) / 2;
               if (!outranks(heap_mem[pos], heap_mem[parent])) begin
                  break;
               end
               swap_slots(pos, parent);
               pos = parent;
            end
         end
      end else begin
         if (heap_fill == 0) begin
            err = 1'b1;
         end else begin
            heap_fill--;
            if (heap_fill > 0) begin
               heap_mem[0] = heap_mem[heap_fill];
               pos = 0;
               while (1) begin
                  left = 2 * pos + 1;
                  best = pos;
                  if (left < heap_fill && outranks(heap_mem[left], heap_mem[best])) begin
                     best = left;
                  end
                  if (left + 1 < heap_fill && outranks(heap_mem[left + 1], heap_mem[best])) begin
                     best = left + 1;
                  end
                  if (best == pos) begin
                     break;
                  end
                  swap_slots(pos, best);
                  pos = best;
               end
            end
         end
      end
      res.root_value  = (heap_fill > 0) ? heap_mem[0] : '0;
      res.is_empty    = (heap_fill == 0);
      res.entry_count = heap_fill[COUNT_FIELD_W-1:0];
      res.req_error   = err;
      return res;
   endfunction

   function automatic int draw_gap();
      return phase_idle ? $urandom_range(0, 13) : 0;
   endfunction

   function automatic logic signed [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 5))
         0, 1: begin
            return $urandom;
         end
         2: begin
            return 32'($urandom_range(0, 8)) - 32'd4;
         end
         3: begin
            return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
         end
         4: begin
            return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF - $urandom_range(0, 3)
                                               : 32'h8000_0000 + $urandom_range(0, 3);
         end
         default: begin
            return ($urandom_range(0, 1) != 0) ? 32'sd7 : -32'sd7;
         end
      endcase
   endfunction

   task automatic add_req(input logic kind, input logic signed [VALUE_W-1:0] value);
      job_type job;
      job.kind               = JOB_REQ;
      job.req.req_type       = kind;
      job.req.push_value     = (kind == REQ_PUSH) ? value : $urandom;
      job.csr_value          = 1'b0;
      job.gap                = draw_gap();
      pending_jobs = {pending_jobs, job};
   endtask

   task automatic add_csr(input logic value);
      job_type job;
      job.kind      = JOB_CSR;
      job.req       = '0;
      job.csr_value = value;
      job.gap       = 0;
      pending_jobs = {pending_jobs, job};
   endtask

   task automatic add_drain();
      job_type job;
      job.kind      = JOB_DRAIN;
      job.req       = '0;
      job.csr_value = 1'b0;
      job.gap       = 0;
      pending_jobs = {pending_jobs, job};
   endtask

   always @(posedge clock) begin : driver
      logic    next_start;
      logic    next_csr;
      job_type job;
      if (reset) begin
         start     <= 1'b0;
         csr_valid <= 1'b0;
         heap_fill = 0;
         heap_max  = 1'b1;
      end else begin
         next_start = start;
         next_csr   = csr_valid;
         if (start && !busy) begin
            expected_status = {expected_status, heap_apply(req_data)};
            items_issued++;
            next_start = 1'b0;
         end
         if (csr_valid && csr_ready) begin
            heap_max = csr_wdata;
            next_csr = 1'b0;
         end
         if (!next_start && !next_csr) begin
            if (wait_cycles > 0) begin
               wait_cycles--;
            end else if (pending_jobs.size() > 0) begin
               job = pending_jobs[0];
               if (job.kind == JOB_DRAIN) begin
                  if (items_issued == results_seen) begin
                     job = pending_jobs.pop_front();
                  end
               end else if (job.kind == JOB_CSR) begin
                  if (items_issued == results_seen) begin
                     csr_wdata <= job.csr_value;
                     next_csr = 1'b1;
                     job = pending_jobs.pop_front();
                  end
               end else if (!gap_loaded && job.gap > 0) begin
                  wait_cycles = job.gap - 1;
                  gap_loaded  = 1'b1;
               end else begin
                  gap_loaded = 1'b0;
                  req_data   <= job.req;
                  next_start = 1'b1;
                  job = pending_jobs.pop_front();
               end
            end
         end
         start     <= next_start;
         csr_valid <= next_csr;
      end
   end

   always @(posedge clock) begin : monitor
      bhpq_rsp_type want;
      if (!reset && rsp_valid) begin
         results_seen <= results_seen + 1;
         if (expected_status.size() == 0) begin
            mismatch_count++;
            $display("%0t: result with no request outstanding: got %p", $time, rsp_data);
         end else begin
            want = expected_status.pop_front();
            if (rsp_data.root_value !== want.root_value) begin
               mismatch_count++;
               $display("%0t: root_value expected %0d got %0d", $time,
                        want.root_value, rsp_data.root_value);
            end
            if (rsp_data.is_empty !== want.is_empty) begin
               mismatch_count++;
               $display("%0t: is_empty expected %0b got %0b", $time,
                        want.is_empty, rsp_data.is_empty);
            end
            if (rsp_data.entry_count !== want.entry_count) begin
               mismatch_count++;
               $display("%0t: entry_count expected %0d got %0d", $time,
                        want.entry_count, rsp_data.entry_count);
            end
            if (rsp_data.req_error !== want.req_error) begin
               mismatch_count++;
               $display("%0t: req_error expected %0b got %0b", $time,
                        want.req_error, rsp_data.req_error);
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      int phase;
      int done;
      int len;
      int k;
      int gen_fill;

      // Directed part under the reset ordering, then min ordering.
      add_req(REQ_POP, 0);
      add_req(REQ_PUSH, 5);
      add_req(REQ_PUSH, 32'h7FFF_FFFF);
      add_req(REQ_PUSH, 32'h8000_0000);
      add_req(REQ_PUSH, -1);
      add_req(REQ_PUSH, 0);
      add_req(REQ_PUSH, 5);
      for (k = 0; k < 6; k++) begin
         add_req(REQ_POP, 0);
      end
      add_req(REQ_POP, 0);
      add_csr(1'b0);
      add_req(REQ_PUSH, -3);
      add_req(REQ_PUSH, 32'h7FFF_FFFF);
      add_req(REQ_PUSH, 32'h8000_0000);
      add_req(REQ_PUSH, -3);
      add_req(REQ_PUSH, 32'h7FFF_FFFF);
      for (k = 0; k < 5; k++) begin
         add_req(REQ_POP, 0);
      end
      add_req(REQ_POP, 0);
      add_csr(1'b1);

      // Grow a deep heap, then change the ordering and drain it.
      phase_idle = 1'b0;
      for (k = 0; k < FILL_ITEMS; k++) begin
         add_req(REQ_PUSH, pick_value());
      end
      phase_idle = 1'b1;
      for (k = 0; k < 3; k++) begin
         add_req(REQ_PUSH, pick_value());
      end
      add_req(REQ_POP, 0);
      add_req(REQ_PUSH, pick_value());
      add_req(REQ_PUSH, pick_value());
      add_csr(1'b0);
      phase_idle = 1'b0;
      for (k = 0; k < FILL_ITEMS + 4; k++) begin
         add_req(REQ_POP, 0);
      end
      phase_idle = 1'b1;
      add_req(REQ_POP, 0);

      // Random phases built mostly from push runs and pop runs.
      gen_fill = 0;
      for (phase = 0; phase < 6; phase++) begin
         add_drain();
         add_csr((phase < 2) ? phase[0] : logic'($urandom_range(0, 1)));
         phase_idle = (phase % 4 != 1);
         done = 0;
         while (done < 64) begin
            case ($urandom_range(0, 5))
               0, 1: begin
                  len = $urandom_range(1, 20);
                  for (k = 0; k < len; k++) begin
                     add_req(REQ_PUSH, pick_value());
                  end
                  gen_fill += len;
               end
               2, 3: begin
                  len = (gen_fill > 0) ? $urandom_range(1, gen_fill) : 1;
                  for (k = 0; k < len; k++) begin
                     add_req(REQ_POP, 0);
                  end
                  gen_fill = (gen_fill > len) ? gen_fill - len : 0;
               end
               4: begin
                  len = gen_fill + $urandom_range(1, 3);
                  for (k = 0; k < len; k++) begin
                     add_req(REQ_POP, 0);
                  end
                  gen_fill = 0;
               end
               default: begin
                  len = $urandom_range(2, 12);
                  for (k = 0; k < len; k++) begin
                     if ($urandom_range(0, 1) != 0) begin
                        add_req(REQ_PUSH, pick_value());
                        gen_fill++;
                     end else begin
                        add_req(REQ_POP, 0);
                        gen_fill = (gen_fill > 0) ? gen_fill - 1 : 0;
                     end
                  end
               end
            endcase
            done += len;
         end
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      do begin
         @(negedge clock);
      end while (pending_jobs.size() != 0 || start || csr_valid
                 || expected_status.size() != 0);
      repeat (TAIL_CYCLES) @(negedge clock);

      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
